// ===== rtl/rfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle fill and blend engine package
// Sizes, command codes, the state type, the controller/datapath command and
// status structs, and the shared pixel arithmetic.
// ----------------------------------------------------------------------------
package rfb_pkg;

  // Frame store geometry.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int PIX_W      = 32;

  // Canvas registers and pixel coordinates.
  localparam int CANVAS_W = 7;
  localparam int COORD_W  = CANVAS_W;
  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  // Command codes.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // What a pixel operation writes back.
  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_CLEAR,
    MODE_BLEND
  } pix_mode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_INIT_DRAIN,
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_RD_DATA,
    ST_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic      load;
    logic      issue;
    pix_mode_t mode;
    logic      init_sel;
    logic      rd_sel_read;
    logic      capture;
    logic      load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       region_empty;
    logic       walk_last;
    logic       init_last;
    logic       pipe_busy;
  } dp_sts_t;

  // Exact floor(v / 255) for v up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // Unsigned add saturating at 255.
  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // Word address of the pixel at column x, row y.
  function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] y,
                                                 input logic [COORD_W-1:0] x);
    return ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

endpackage

// ===== rtl/rfb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle fill and blend datapath
// Canvas registers, command capture and clipping, the pixel walk counters,
// the frame memory and the three-stage read-modify-write blend pipeline.
// ----------------------------------------------------------------------------
module rfb_datapath import rfb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic                cfg_index,
  input  logic [CANVAS_W-1:0] cfg_data,
  input  logic [1:0]          command,
  input  logic signed [8:0]   left,
  input  logic signed [8:0]   top,
  input  logic signed [8:0]   right,
  input  logic signed [8:0]   bottom,
  input  logic [7:0]          alpha,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [5:0]          read_x,
  input  logic [5:0]          read_y,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic [7:0]          pixel_alpha,
  output logic [7:0]          pixel_red,
  output logic [7:0]          pixel_green,
  output logic [7:0]          pixel_blue
);

  logic [CANVAS_W-1:0] canvas_w;
  logic [CANVAS_W-1:0] canvas_h;
  logic [CANVAS_W-1:0] eff_w;
  logic [CANVAS_W-1:0] eff_h;

  // Latched item.
  logic [1:0]        cmd_code;
  logic [7:0]        src_a;
  logic [7:0]        src_r;
  logic [7:0]        src_g;
  logic [7:0]        src_b;
  logic [ADDR_W-1:0] read_addr;
  logic              rd_in_range;

  // Premultiplied source.
  logic [15:0] pm_prod_r;
  logic [15:0] pm_prod_g;
  logic [15:0] pm_prod_b;
  logic [7:0]  pm_r;
  logic [7:0]  pm_g;
  logic [7:0]  pm_b;

  // Region and walk.
  logic signed [9:0]  lft;
  logic signed [9:0]  tp;
  logic signed [9:0]  rgt;
  logic signed [9:0]  btm;
  logic signed [9:0]  wide_w;
  logic signed [9:0]  wide_h;
  logic signed [9:0]  lc;
  logic signed [9:0]  tc;
  logic signed [9:0]  rc;
  logic signed [9:0]  bc;
  logic [COORD_W-1:0] x0_next;
  logic [COORD_W-1:0] x1_next;
  logic [COORD_W-1:0] y0_next;
  logic [COORD_W-1:0] y1_next;
  logic               empty_next;
  logic [COORD_W-1:0] x0;
  logic [COORD_W-1:0] x1;
  logic [COORD_W-1:0] y1;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic               region_empty;
  logic               row_end;
  logic [ADDR_W-1:0]  init_addr;

  // Memory and pipeline.
  logic [PIX_W-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rdata;
  logic              p1_valid;
  pix_mode_t         p1_mode;
  logic [ADDR_W-1:0] p1_addr;
  logic              p2_valid;
  pix_mode_t         p2_mode;
  logic [ADDR_W-1:0] p2_addr;
  logic              p2_dzero;
  logic [3:0][15:0]  p2_prod;
  logic [7:0]        inv_a;
  logic [3:0][7:0]   src_vec;
  logic [3:0][7:0]   blend;
  logic [PIX_W-1:0]  wdata;
  logic [PIX_W-1:0]  res_pixel;

  // Configuration registers and the canvas clamped to the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_w <= CANVAS_RESET;
      canvas_h <= CANVAS_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_w <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w = (int'(canvas_w) > MAX_WIDTH)  ? CANVAS_W'(MAX_WIDTH)  : canvas_w;
  assign eff_h = (int'(canvas_h) > MAX_HEIGHT) ? CANVAS_W'(MAX_HEIGHT) : canvas_h;

  // Clip the rectangle, or pick the whole canvas for a clear.
  always_comb begin
    lft    = {left[8], left};
    tp     = {top[8], top};
    rgt    = {right[8], right};
    btm    = {bottom[8], bottom};
    wide_w = {3'b000, eff_w};
    wide_h = {3'b000, eff_h};
    lc     = (lft < 0) ? 10'sd0 : lft;
    tc     = (tp < 0) ? 10'sd0 : tp;
    rc     = (rgt > wide_w) ? wide_w : rgt;
    bc     = (btm > wide_h) ? wide_h : btm;
    case (command)
      CMD_CLEAR: begin
        x0_next    = '0;
        x1_next    = eff_w;
        y0_next    = '0;
        y1_next    = eff_h;
        empty_next = (eff_w == '0) || (eff_h == '0);
      end
      CMD_FILL: begin
        x0_next    = lc[COORD_W-1:0];
        x1_next    = rc[COORD_W-1:0];
        y0_next    = tc[COORD_W-1:0];
        y1_next    = bc[COORD_W-1:0];
        empty_next = (alpha == 8'd0) || (lc >= rc) || (tc >= bc);
      end
      default: begin
        x0_next    = '0;
        x1_next    = '0;
        y0_next    = '0;
        y1_next    = '0;
        empty_next = 1'b1;
      end
    endcase
  end

  // Item capture and the walk over the region, one pixel per issue.
  assign row_end = (cur_x == COORD_W'(x1 - 1'b1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_code     <= command;
      src_a        <= alpha;
      src_r        <= red;
      src_g        <= green;
      src_b        <= blue;
      read_addr    <= pix_addr(COORD_W'(read_y), COORD_W'(read_x));
      rd_in_range  <= (COORD_W'(read_x) < eff_w) && (COORD_W'(read_y) < eff_h);
      x0           <= x0_next;
      x1           <= x1_next;
      y1           <= y1_next;
      cur_x        <= x0_next;
      cur_y        <= y0_next;
      region_empty <= empty_next;
    end else if (cmd.issue && !cmd.init_sel) begin
      if (row_end) begin
        cur_x <= x0;
        cur_y <= COORD_W'(cur_y + 1'b1);
      end else begin
        cur_x <= COORD_W'(cur_x + 1'b1);
      end
    end
  end

  // Sweep counter for the clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
    end else if (cmd.issue && cmd.init_sel) begin
      init_addr <= ADDR_W'(init_addr + 1'b1);
    end
  end

  // Premultiply the source color: product, then divide by 255.
  always_ff @(posedge clk) begin
    pm_prod_r <= 16'(src_r) * 16'(src_a);
    pm_prod_g <= 16'(src_g) * 16'(src_a);
    pm_prod_b <= 16'(src_b) * 16'(src_a);
    pm_r      <= div255(pm_prod_r);
    pm_g      <= div255(pm_prod_g);
    pm_b      <= div255(pm_prod_b);
  end

  // Frame memory read address.
  always_comb begin
    if (cmd.init_sel) begin
      rd_addr = init_addr;
    end else if (cmd.rd_sel_read) begin
      rd_addr = read_addr;
    end else begin
      rd_addr = pix_addr(cur_y, cur_x);
    end
  end

  // Frame memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (p2_valid) begin
      mem[p2_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // Stage one tracks the read; stage two holds the destination products.
  assign inv_a = 8'(8'd255 - src_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.issue;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_mode  <= cmd.mode;
    p1_addr  <= rd_addr;
    p2_mode  <= p1_mode;
    p2_addr  <= p1_addr;
    p2_dzero <= (rdata[31:24] == 8'd0);
    for (int i = 0; i < 4; i++) begin
      p2_prod[i] <= 16'(rdata[i*8 +: 8]) * 16'(inv_a);
    end
  end

  // Source-over blend and the write-back choice.
  assign src_vec = {src_a, pm_r, pm_g, pm_b};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      blend[i] = sat_add(src_vec[i], div255(p2_prod[i]));
    end
    case (p2_mode)
      MODE_ZERO:  wdata = '0;
      MODE_CLEAR: wdata = src_vec;
      MODE_BLEND: wdata = p2_dzero ? src_vec : blend;
      default:    wdata = '0;
    endcase
  end

  // Result capture and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_pixel <= '0;
    end else if (cmd.capture) begin
      res_pixel <= rd_in_range ? rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_alpha <= res_pixel[31:24];
      pixel_red   <= res_pixel[23:16];
      pixel_green <= res_pixel[15:8];
      pixel_blue  <= res_pixel[7:0];
    end
  end

  // Status to the controller.
  assign sts.cmd          = cmd_code;
  assign sts.region_empty = region_empty;
  assign sts.walk_last    = row_end && (cur_y == COORD_W'(y1 - 1'b1));
  assign sts.init_last    = (init_addr == ADDR_W'(DEPTH - 1));
  assign sts.pipe_busy    = p1_valid || p2_valid;

`ifndef SYNTH
  // Two pixels in flight never share a word.
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    p1_valid && p2_valid |-> p1_addr != p2_addr)
    else $error("read-modify-write overlap in blend pipeline");

  // A read outside the canvas returns a zero pixel.
  a_read_outside_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.capture && !rd_in_range |=> res_pixel == '0)
    else $error("read outside canvas returned nonzero pixel");

  // Every write lands inside the frame store.
  a_write_in_store: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> int'(p2_addr) < DEPTH)
    else $error("write address beyond frame store");
`endif

endmodule

// ===== rtl/rfb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle fill and blend controller
// Sequences the clearing pass, item capture, source premultiply, the pixel
// walk, pipeline drain, pixel read and the output handshake.
// ----------------------------------------------------------------------------
module rfb_ctrl import rfb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sts.init_last) state_next = ST_INIT_DRAIN;
      end
      ST_INIT_DRAIN: begin
        if (!sts.pipe_busy) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_PREP1;
      end
      ST_PREP1: state_next = ST_PREP2;
      ST_PREP2: begin
        case (sts.cmd)
          CMD_CLEAR, CMD_FILL: state_next = sts.region_empty ? ST_FINISH : ST_WALK;
          CMD_READ:            state_next = ST_READ;
          default:             state_next = ST_FINISH;
        endcase
      end
      ST_WALK: begin
        if (sts.walk_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_next = ST_FINISH;
      end
      ST_READ:    state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Datapath commands and the input handshake.
  always_comb begin
    in_stall        = 1'b1;
    cmd.load        = 1'b0;
    cmd.issue       = 1'b0;
    cmd.mode        = (sts.cmd == CMD_CLEAR) ? MODE_CLEAR : MODE_BLEND;
    cmd.init_sel    = 1'b0;
    cmd.rd_sel_read = 1'b0;
    cmd.capture     = 1'b0;
    cmd.load_out    = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.issue    = 1'b1;
        cmd.init_sel = 1'b1;
        cmd.mode     = MODE_ZERO;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_WALK:    cmd.issue       = 1'b1;
      ST_READ:    cmd.rd_sel_read = 1'b1;
      ST_RD_DATA: cmd.capture     = 1'b1;
      ST_FINISH:  cmd.load_out    = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  // All pixel writes of an item are done before its result is loaded.
  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !sts.pipe_busy)
    else $error("result loaded with writes still in flight");

  // A new item is taken only with the blend pipeline empty.
  a_accept_drained: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !sts.pipe_busy)
    else $error("item accepted with pipeline busy");

  // No result appears during the clearing pass.
  a_init_no_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_INIT |-> !out_valid)
    else $error("result valid during clearing pass");
`endif

endmodule

// ===== rtl/rect_fill_blend_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle fill and blend engine
// 2D fill engine owning a premultiplied ARGB frame store: clear, clipped
// source-over rectangle fill and single pixel read.
// ----------------------------------------------------------------------------
// The engine takes one item at a time. After reset it first zeroes the
// frame store, one word per cycle, and the pipeline then drains; in_stall
// stays high through both. Configuration writes are taken at any time. A
// clear or a fill walks the covered pixels, one per cycle, and then drains
// the pipeline before its result is loaded. An empty rectangle, zero alpha
// or an unused command skips the walk, and a read fetches a single pixel
// of the frame store. The per-pixel rate is set by the frame memory, which
// does one read and one write per cycle through a three-stage read,
// multiply and blend pipeline. A finished result waits in an output
// register, so the next item is accepted while it is still stalled.
// ----------------------------------------------------------------------------
module rect_fill_blend_engine import rfb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic                cfg_index,
  input  logic [CANVAS_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic signed [8:0]   left,
  input  logic signed [8:0]   top,
  input  logic signed [8:0]   right,
  input  logic signed [8:0]   bottom,
  input  logic [7:0]          alpha,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [5:0]          read_x,
  input  logic [5:0]          read_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          pixel_alpha,
  output logic [7:0]          pixel_red,
  output logic [7:0]          pixel_green,
  output logic [7:0]          pixel_blue,
  output logic                done_res
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  rfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Frame store, clipping and blend pipeline.
  rfb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .left         (left),
    .top          (top),
    .right        (right),
    .bottom       (bottom),
    .alpha        (alpha),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .read_x       (read_x),
    .read_y       (read_y),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_alpha  (pixel_alpha),
    .pixel_red    (pixel_red),
    .pixel_green  (pixel_green),
    .pixel_blue   (pixel_blue)
  );

  // Every item completes.
  assign done_res = 1'b1;

endmodule
